[src/hob_pkg.sv]
// Shared constants, codes and control types for the Hall/observer angle blend.
package hob_pkg;

   // Fixed-point constants in the angle and weight formats.
   localparam int Q15_ONE_I         = 32767;
   localparam int W_EIGHT_TENTHS_I  = Q15_ONE_I * 8 / 10;
   localparam int W_THREE_QUART_I   = Q15_ONE_I * 3 / 4;
   localparam int W_QUARTER_I       = Q15_ONE_I / 4;
   localparam int PI_Q16_I          = 205888;
   localparam int TWO_PI_Q16_I      = 411775;
   localparam int HYSTERESIS_DEF    = 328;

   localparam logic [14:0] Q15_ONE        = 15'(Q15_ONE_I);
   localparam logic [14:0] W_EIGHT_TENTHS = 15'(W_EIGHT_TENTHS_I);
   localparam logic [14:0] W_THREE_QUART  = 15'(W_THREE_QUART_I);
   localparam logic [14:0] W_QUARTER      = 15'(W_QUARTER_I);

   // Divider geometry: the quotient is known to fit in DIV_STEPS bits.
   localparam int NUM_W     = 34;
   localparam int DEN_W     = 19;
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Speed regions.
   localparam logic [2:0] RGN_HALL  = 3'd0;
   localparam logic [2:0] RGN_OBS   = 3'd1;
   localparam logic [2:0] RGN_UPPER = 3'd2;
   localparam logic [2:0] RGN_MAIN  = 3'd3;
   localparam logic [2:0] RGN_LOW   = 3'd4;

   // Source codes on the result.
   localparam logic [1:0] SRC_HALL  = 2'd0;
   localparam logic [1:0] SRC_OBS   = 2'd1;
   localparam logic [1:0] SRC_BLEND = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_HALL_ONLY   = 3'd0;
   localparam logic [2:0] REG_BLEND_START = 3'd1;
   localparam logic [2:0] REG_BLEND_END   = 3'd2;
   localparam logic [2:0] REG_OBS_ONLY    = 3'd3;
   localparam logic [2:0] REG_MIS_LIMIT   = 3'd4;
   localparam logic [2:0] REG_MIS_COUNT   = 3'd5;
   localparam logic [2:0] REG_RATE_UP     = 3'd6;
   localparam logic [2:0] REG_RATE_DOWN   = 3'd7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic calc;
      logic hyst;
      logic mul_rate;
      logic rate;
      logic mul_fuse;
      logic load_out;
   } hob_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
   } hob_sts_type;

endpackage

[src/hob_div.sv]
// Restoring divider, one quotient bit per cycle, for the ramp weight.
module hob_div
   import hob_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output logic [DIV_STEPS-1:0] quot,
   output logic                 done
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]       rem_ff, rem_in;
   logic [DIV_STEPS-1:0] low_ff, low_in;
   logic [DIV_STEPS-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W:0]       trial;

   // One shift-and-subtract step per cycle while busy.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      trial   = {rem_ff[DEN_W-1:0], low_ff[DIV_STEPS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = (DEN_W+1)'(num[NUM_W-1:DIV_STEPS]);
         low_in  = num[DIV_STEPS-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         low_in = {low_ff[DIV_STEPS-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[DIV_STEPS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

`ifndef SYNTHESIS
   // Completion is only ever flagged at the end of a running division.
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
`endif

endmodule

[src/hob_dp.sv]
// Datapath: configuration, blend state, speed-to-weight, rate limit and angle fusion.
module hob_dp
   import hob_pkg::*;
#(
   parameter int HYSTERESIS_STEP = HYSTERESIS_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  hob_cmd_type        cmd,
   output hob_sts_type        sts,
   input  logic [18:0]        hall_angle,
   input  logic [18:0]        observer_angle,
   input  logic               hall_valid,
   input  logic               observer_tracking,
   input  logic signed [15:0] speed,
   input  logic [15:0]        tick_period,
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [17:0]        csr_wdata,
   output logic [18:0]        fused_angle,
   output logic [1:0]         source,
   output logic [14:0]        blend_weight,
   output logic signed [18:0] angle_gap,
   output logic               mismatch_fault,
   output logic               in_transition
);

   // Configuration registers.
   logic [14:0] hall_only_ff, blend_start_ff, blend_end_ff, obs_only_ff;
   logic [17:0] mis_limit_ff;
   logic [15:0] mis_count_lim_ff;
   logic [14:0] rate_up_ff, rate_down_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hall_only_ff     <= '0;
         blend_start_ff   <= '0;
         blend_end_ff     <= '0;
         obs_only_ff      <= '0;
         mis_limit_ff     <= '0;
         mis_count_lim_ff <= '0;
         rate_up_ff       <= '0;
         rate_down_ff     <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_HALL_ONLY:   hall_only_ff     <= csr_wdata[14:0];
            REG_BLEND_START: blend_start_ff   <= csr_wdata[14:0];
            REG_BLEND_END:   blend_end_ff     <= csr_wdata[14:0];
            REG_OBS_ONLY:    obs_only_ff      <= csr_wdata[14:0];
            REG_MIS_LIMIT:   mis_limit_ff     <= csr_wdata;
            REG_MIS_COUNT:   mis_count_lim_ff <= csr_wdata[15:0];
            REG_RATE_UP:     rate_up_ff       <= csr_wdata[14:0];
            REG_RATE_DOWN:   rate_down_ff     <= csr_wdata[14:0];
            default:         rate_down_ff     <= rate_down_ff;
         endcase
      end
   end

   // Captured request.
   logic [18:0]        hall_ff, obs_ff;
   logic               hv_ff, ot_ff;
   logic signed [15:0] spd_ff;
   logic [15:0]        dt_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hall_ff <= hall_angle;
         obs_ff  <= observer_angle;
         hv_ff   <= hall_valid;
         ot_ff   <= observer_tracking;
         spd_ff  <= speed;
         dt_ff   <= tick_period;
      end
   end

   // Blend state.
   logic [14:0] weight_ff, weight_in;
   logic        hall_side_ff, hall_side_in;
   logic        obs_side_ff, obs_side_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        fault_ff, fault_in;
   logic [18:0] gap_ff;
   logic [2:0]  rgn_ff;
   logic        rng_zero_ff;
   logic [14:0] tgt_ff;
   logic signed [36:0] prod_ff;

   // Speed magnitude, wrapped gap and region selection.
   logic [15:0]        spd_mag;
   logic [14:0]        s_abs;
   logic signed [19:0] diff, gap_w;
   logic [18:0]        agap;
   logic [2:0]         rgn_c;
   logic [14:0]        lo_c, hi_c, rng_c, pos_c;
   logic [29:0]        pos_q15;
   logic [NUM_W-1:0]   num_c;
   logic [DEN_W-1:0]   den_c;
   logic [15:0]        cnt_inc;

   always_comb begin
      spd_mag = spd_ff[15] ? (~spd_ff + 16'd1) : spd_ff;
      s_abs   = spd_mag[15] ? Q15_ONE : spd_mag[14:0];
      diff    = $signed({1'b0, obs_ff}) - $signed({1'b0, hall_ff});
      if (diff > 20'sd205888)       gap_w = diff - 20'(TWO_PI_Q16_I);
      else if (diff < -20'sd205888) gap_w = diff + 20'(TWO_PI_Q16_I);
      else                          gap_w = diff;
      agap = gap_w[19] ? 19'(-gap_w) : gap_w[18:0];

      lo_c = hall_only_ff;
      hi_c = blend_start_ff;
      if (s_abs <= hall_only_ff) begin
         rgn_c = RGN_HALL;
      end else if (s_abs >= obs_only_ff) begin
         rgn_c = RGN_OBS;
      end else if (s_abs >= blend_end_ff) begin
         rgn_c = RGN_UPPER;
         lo_c  = blend_end_ff;
         hi_c  = obs_only_ff;
      end else if (s_abs >= blend_start_ff) begin
         rgn_c = RGN_MAIN;
         lo_c  = blend_start_ff;
         hi_c  = blend_end_ff;
      end else begin
         rgn_c = RGN_LOW;
      end
      rng_c   = hi_c - lo_c;
      pos_c   = s_abs - lo_c;
      // pos * 32767 by shift and subtract; the ramp scale folds into num_c and den_c.
      pos_q15 = {pos_c, 15'd0} - {15'd0, pos_c};
      if (rgn_c == RGN_MAIN) begin
         num_c = {1'b0, pos_q15, 3'd0};
         den_c = {1'b0, rng_c, 3'd0} + {3'd0, rng_c, 1'b0};
      end else if (rgn_c == RGN_UPPER) begin
         num_c = {4'd0, pos_q15};
         den_c = {2'd0, rng_c, 2'd0} + {4'd0, rng_c};
      end else begin
         num_c = {4'd0, pos_q15};
         den_c = {1'b0, rng_c, 3'd0} + {3'd0, rng_c, 1'b0};
      end

      // Mismatch supervision with a saturating counter.
      cnt_in   = cnt_ff;
      fault_in = fault_ff;
      cnt_inc  = (cnt_ff == 16'hFFFF) ? cnt_ff : cnt_ff + 16'd1;
      if (cmd.calc) begin
         if (agap > {1'b0, mis_limit_ff}) begin
            cnt_in = cnt_inc;
            if (cnt_inc > mis_count_lim_ff) fault_in = 1'b1;
         end else begin
            cnt_in   = (cnt_ff != 16'd0) ? cnt_ff - 16'd1 : cnt_ff;
            fault_in = 1'b0;
         end
      end
   end

   logic [DIV_STEPS-1:0] quot;
   logic                 div_done;

   hob_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.calc),
      .num   (num_c),
      .den   (den_c),
      .quot  (quot),
      .done  (div_done)
   );

   assign sts.div_done = div_done;

   // Target weight from the region, then the hysteresis step limit.
   logic [14:0] tgt0, tgt_c;
   logic [16:0] w17, hs17, up_lim, dn_lim;

   always_comb begin
      case (rgn_ff)
         RGN_HALL:  tgt0 = 15'd0;
         RGN_OBS:   tgt0 = Q15_ONE;
         RGN_UPPER: tgt0 = W_EIGHT_TENTHS + quot[14:0];
         default:   tgt0 = quot[14:0];
      endcase
      if (rng_zero_ff && rgn_ff != RGN_HALL && rgn_ff != RGN_OBS) tgt0 = 15'd0;
      w17    = {2'd0, weight_ff};
      hs17   = 17'(HYSTERESIS_STEP);
      up_lim = w17 + hs17;
      dn_lim = w17 - hs17;
      tgt_c  = tgt0;
      if (hall_side_ff && tgt0 > weight_ff) begin
         if (up_lim < {2'd0, tgt0}) tgt_c = up_lim[14:0];
      end else if (obs_side_ff && tgt0 < weight_ff) begin
         if ($signed(dn_lim) > $signed({2'd0, tgt0})) tgt_c = dn_lim[14:0];
      end
   end

   // Shared multiplier: rate times tick period, later gap times weight.
   logic signed [19:0] mul_a;
   logic signed [16:0] mul_b;

   always_comb begin
      if (cmd.mul_fuse) begin
         mul_a = {gap_ff[18], gap_ff};
         mul_b = {2'd0, weight_ff};
      end else begin
         mul_a = {5'd0, (tgt_ff > weight_ff) ? rate_up_ff : rate_down_ff};
         mul_b = {1'b0, dt_ff};
      end
   end

   // Rate-limited weight step and side flags from the old weight.
   logic [15:0] step, step_e;
   logic [16:0] sum17, dif17;

   always_comb begin
      step      = prod_ff[31:16];
      step_e    = (step == 16'd0) ? 16'd1 : step;
      sum17     = w17 + {1'b0, step_e};
      dif17     = w17 - {1'b0, step_e};
      weight_in = weight_ff;
      if (tgt_ff > weight_ff) begin
         weight_in = (sum17 > {2'd0, tgt_ff}) ? tgt_ff : sum17[14:0];
      end else if (tgt_ff < weight_ff) begin
         weight_in = ($signed(dif17) < $signed({2'd0, tgt_ff})) ? tgt_ff : dif17[14:0];
      end
      hall_side_in = hall_side_ff;
      obs_side_in  = obs_side_ff;
      if (weight_ff < W_QUARTER) begin
         hall_side_in = 1'b1;
         obs_side_in  = 1'b0;
      end else if (weight_ff > W_THREE_QUART) begin
         hall_side_in = 1'b0;
         obs_side_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= '0;
         hall_side_ff <= 1'b1;
         obs_side_ff  <= 1'b0;
         cnt_ff       <= '0;
         fault_ff     <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         fault_ff <= fault_in;
         if (cmd.rate) begin
            weight_ff    <= weight_in;
            hall_side_ff <= hall_side_in;
            obs_side_ff  <= obs_side_in;
         end
      end
      if (cmd.calc) begin
         gap_ff      <= gap_w[18:0];
         rgn_ff      <= rgn_c;
         rng_zero_ff <= (rng_c == 15'd0);
      end
      if (cmd.hyst) tgt_ff <= tgt_c;
      if (cmd.mul_rate || cmd.mul_fuse) prod_ff <= 37'(mul_a) * 37'(mul_b);
   end

   // Angle fusion along the shortest arc.
   logic signed [19:0] offs;
   logic signed [20:0] fsum, fwrap;
   logic [18:0]        fused_c;
   logic [1:0]         src_rgn, src_c;

   always_comb begin
      offs = prod_ff[34:15];
      fsum = $signed({2'd0, hall_ff}) + 21'(offs);
      if (fsum >= 21'sd411775) fwrap = fsum - 21'sd411775;
      else if (fsum < 21'sd0)  fwrap = fsum + 21'sd411775;
      else                     fwrap = fsum;
      case (rgn_ff)
         RGN_OBS:   src_rgn = SRC_OBS;
         RGN_UPPER: src_rgn = SRC_BLEND;
         RGN_MAIN:  src_rgn = SRC_BLEND;
         default:   src_rgn = SRC_HALL;
      endcase
      if (!hv_ff) begin
         fused_c = obs_ff;
         src_c   = SRC_OBS;
      end else if (!ot_ff) begin
         fused_c = hall_ff;
         src_c   = SRC_HALL;
      end else if (weight_ff == 15'd0) begin
         fused_c = hall_ff;
         src_c   = src_rgn;
      end else if (weight_ff == Q15_ONE) begin
         fused_c = obs_ff;
         src_c   = src_rgn;
      end else begin
         fused_c = fwrap[18:0];
         src_c   = SRC_BLEND;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         fused_angle    <= fused_c;
         source         <= src_c;
         blend_weight   <= weight_ff;
         angle_gap      <= gap_ff;
         mismatch_fault <= fault_ff;
         in_transition  <= (rgn_ff == RGN_UPPER) || (rgn_ff == RGN_MAIN);
      end
   end

`ifndef SYNTHESIS
   // The fault can only stand while mismatches have been counted.
   a_fault_has_count: assert property (@(posedge clock) disable iff (reset)
      fault_ff |-> (cnt_ff != 16'd0))
      else $error("mismatch fault set with an empty counter");
`endif

endmodule

[src/hob_ctrl.sv]
// Controller: sequences one request through divider, rate limit and fusion.
module hob_ctrl
   import hob_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  hob_sts_type sts,
   output hob_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CALC = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_HYST = 3'd3;
   localparam logic [2:0] S_RMUL = 3'd4;
   localparam logic [2:0] S_RATE = 3'd5;
   localparam logic [2:0] S_FMUL = 3'd6;
   localparam logic [2:0] S_FUSE = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      out_free = !rsp_valid_ff || rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_HYST;
         end
         S_HYST: begin
            cmd.hyst = 1'b1;
            state_in = S_RMUL;
         end
         S_RMUL: begin
            cmd.mul_rate = 1'b1;
            state_in     = S_RATE;
         end
         S_RATE: begin
            cmd.rate = 1'b1;
            state_in = S_FMUL;
         end
         S_FMUL: begin
            cmd.mul_fuse = 1'b1;
            state_in     = S_FUSE;
         end
         S_FUSE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.load_out)    rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   // An accepted request always starts the calculation step.
   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_CALC))
      else $error("accepted request did not start calculation");

   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while full");
`endif

endmodule

[src/hall_observer_angle_blend.sv]
// Top level of the Hall/observer rotor-angle blend.
//
// Usage: one request per control tick on the req_ stream carries both rotor
// angles, the validity flags, the signed speed and the tick period. One
// response per request on the rsp_ stream carries the fused angle, the source,
// the rate-limited weight, the wrapped angle gap and the status flags.
// Thresholds, mismatch limits and rates are written through the csr_ port;
// the user must do so only while no request is in flight, and the block
// itself does not enforce it. The 16-step divider for the ramp weight takes
// most of the time of a request, and a new request is only accepted once the
// current result is loaded. A finished response waits in its own register,
// so the next request is accepted while it is held; if the receiver stalls
// until the next result is ready, the block holds that result and stops
// accepting until the register frees. Reset clears all configuration, the
// weight, the mismatch counter and the fault flag, sets the side flags to
// the Hall side and empties the response register.
module hall_observer_angle_blend
   import hob_pkg::*;
#(
   parameter int HYSTERESIS_STEP = HYSTERESIS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [18:0] hall_angle, [37:19] observer_angle, [53:38] speed,
   // [69:54] tick_period, [71:70] zero
   input  logic [71:0] req_tdata,
   // [0] hall_valid, [1] observer_tracking
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [18:0] fused_angle, [33:19] blend_weight, [52:34] angle_gap,
   // [53] mismatch_fault, [54] in_transition, [55] zero
   output logic [55:0] rsp_tdata,
   // [1:0] source
   output logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [17:0] csr_wdata
);

   hob_cmd_type        cmd;
   hob_sts_type        sts;
   logic [18:0]        fused_angle;
   logic [1:0]         source;
   logic [14:0]        blend_weight;
   logic signed [18:0] angle_gap;
   logic               mismatch_fault;
   logic               in_transition;

   hob_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hob_dp #(
      .HYSTERESIS_STEP (HYSTERESIS_STEP)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .hall_angle        (req_tdata[18:0]),
      .observer_angle    (req_tdata[37:19]),
      .hall_valid        (req_tuser[0]),
      .observer_tracking (req_tuser[1]),
      .speed             ($signed(req_tdata[53:38])),
      .tick_period       (req_tdata[69:54]),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .fused_angle       (fused_angle),
      .source            (source),
      .blend_weight      (blend_weight),
      .angle_gap         (angle_gap),
      .mismatch_fault    (mismatch_fault),
      .in_transition     (in_transition)
   );

   assign rsp_tdata = {1'b0, in_transition, mismatch_fault, angle_gap,
                       blend_weight, fused_angle};
   assign rsp_tuser = source;

endmodule

[tb/tb.sv]
// Self-checking testbench for the Hall/observer rotor-angle blend.
`timescale 1ns / 1ps

module tb
   import hob_pkg::*;
();

   localparam int HYST = 328;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [17:0] csr_wdata = '0;

   typedef struct packed {
      logic [18:0] fused;
      logic [1:0]  src;
      logic [14:0] wgt;
      logic [18:0] gap;
      logic        fault;
      logic        trans;
   } blend_result_type;

   typedef struct {
      logic [18:0] hall;
      logic [18:0] obs;
      logic        hv;
      logic        ot;
      logic [15:0] speed;
      logic [15:0] dt;
   } tick_type;

   // Directed row: one tick, plus an optional typed-in expectation.
   typedef struct {
      tick_type         tk;
      bit               fixed;
      blend_result_type res;
   } row_type;

   blend_result_type expected_q[$];
   int               failures = 0;

   // Predictor state and its copy of the registers.
   longint        thr[8];
   longint        p_weight;
   bit            p_hall_side, p_obs_side, p_fault;
   longint        p_count;

   hall_observer_angle_blend i_dut (.*);

   always #6 clock = ~clock;

   function automatic longint wrap_gap(longint d);
      if (d > PI_Q16_I) return d - TWO_PI_Q16_I;
      if (d < -PI_Q16_I) return d + TWO_PI_Q16_I;
      return d;
   endfunction

   // Works out the result of one tick and advances the predictor state.
   function automatic blend_result_type predict_blend(tick_type tk);
      blend_result_type r;
      longint hall, obs, spd, s, gap, agap, target, range, pos, step, fused, off, p;
      logic [1:0] src;
      bit trans;
      hall = tk.hall;
      obs = tk.obs;
      spd = $signed(tk.speed);
      s = spd < 0 ? -spd : spd;
      if (s > 32767) s = 32767;
      gap = wrap_gap(obs - hall);
      agap = gap < 0 ? -gap : gap;
      if (agap > thr[REG_MIS_LIMIT]) begin
         if (p_count < 65535) p_count++;
         if (p_count > thr[REG_MIS_COUNT]) p_fault = 1'b1;
      end else begin
         if (p_count > 0) p_count--;
         p_fault = 1'b0;
      end
      if (s <= thr[REG_HALL_ONLY]) begin
         target = 0; src = SRC_HALL; trans = 0;
      end else if (s >= thr[REG_OBS_ONLY]) begin
         target = Q15_ONE_I; src = SRC_OBS; trans = 0;
      end else if (s >= thr[REG_BLEND_END]) begin
         range = thr[REG_OBS_ONLY] - thr[REG_BLEND_END];
         pos = s - thr[REG_BLEND_END];
         target = range > 0 ? W_EIGHT_TENTHS_I + (pos * Q15_ONE_I / 5) / range : 0;
         src = SRC_BLEND; trans = 1;
      end else if (s >= thr[REG_BLEND_START]) begin
         range = thr[REG_BLEND_END] - thr[REG_BLEND_START];
         pos = s - thr[REG_BLEND_START];
         target = range > 0 ? (pos * Q15_ONE_I * 8 / 10) / range : 0;
         src = SRC_BLEND; trans = 1;
      end else begin
         range = thr[REG_BLEND_START] - thr[REG_HALL_ONLY];
         pos = s - thr[REG_HALL_ONLY];
         target = range > 0 ? (pos * Q15_ONE_I / 10) / range : 0;
         src = SRC_HALL; trans = 0;
      end
      // Hysteresis limit around the kept weight.
      if (p_hall_side && target > p_weight) begin
         if (p_weight + HYST < target) target = p_weight + HYST;
      end else if (p_obs_side && target < p_weight) begin
         if (p_weight - HYST > target) target = p_weight - HYST;
      end
      if (p_weight < W_QUARTER_I) begin
         p_hall_side = 1; p_obs_side = 0;
      end else if (p_weight > W_THREE_QUART_I) begin
         p_hall_side = 0; p_obs_side = 1;
      end
      // Rate limit towards the target.
      if (target > p_weight) begin
         step = (thr[REG_RATE_UP] * longint'(tk.dt)) >>> 16;
         if (step < 1) step = 1;
         p_weight += step;
         if (p_weight > target) p_weight = target;
      end else if (target < p_weight) begin
         step = (thr[REG_RATE_DOWN] * longint'(tk.dt)) >>> 16;
         if (step < 1) step = 1;
         p_weight -= step;
         if (p_weight < target) p_weight = target;
      end
      if (!tk.hv) begin
         fused = obs; src = SRC_OBS;
      end else if (!tk.ot) begin
         fused = hall; src = SRC_HALL;
      end else if (p_weight <= 0) begin
         fused = hall;
      end else if (p_weight >= Q15_ONE_I) begin
         fused = obs;
      end else begin
         p = gap * p_weight;
         off = p >= 0 ? (p >>> 15) : -((-p + 32767) >>> 15);
         fused = hall + off;
         while (fused >= TWO_PI_Q16_I) fused -= TWO_PI_Q16_I;
         while (fused < 0) fused += TWO_PI_Q16_I;
         src = SRC_BLEND;
      end
      r.fused = fused[18:0];
      r.src = src;
      r.wgt = p_weight[14:0];
      r.gap = gap[18:0];
      r.fault = p_fault;
      r.trans = trans;
      return r;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      repeat (n) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, longint val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val[17:0];
      thr[idx] = idx == REG_MIS_LIMIT ? (val & 'h3FFFF) :
                 idx == REG_MIS_COUNT ? (val & 'hFFFF) : (val & 'h7FFF);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until all responses are back, then past the block's latency.
   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_thresholds(longint a, longint b, longint c, longint d);
      write_reg(REG_HALL_ONLY, a);
      write_reg(REG_BLEND_START, b);
      write_reg(REG_BLEND_END, c);
      write_reg(REG_OBS_ONLY, d);
   endtask

   task automatic send_tick(tick_type tk, bit fixed, blend_result_type fixed_res);
      blend_result_type r;
      r = predict_blend(tk);
      if (fixed && r != fixed_res) begin
         $error("directed row disagrees with prediction: %h vs %h", fixed_res, r);
         failures++;
      end
      expected_q.push_back(fixed ? fixed_res : r);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b0, tk.dt, tk.speed, tk.obs, tk.hall};
      req_tuser <= {tk.ot, tk.hv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic tick_type random_tick();
      tick_type tk;
      int k;
      k = $urandom_range(0, 9);
      tk.hall = $urandom_range(0, 411774);
      tk.obs = k == 0 ? 19'($urandom) : (k < 4 ? 19'($urandom_range(0, 411774)) :
               19'((tk.hall + $urandom_range(0, 6000) + 408775) % 411775));
      if (k == 1) tk.hall = 19'($urandom);
      tk.hv = $urandom_range(0, 9) != 0;
      tk.ot = $urandom_range(0, 9) != 0;
      tk.speed = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000));
      if ($urandom_range(0, 1)) tk.speed = -tk.speed;
      tk.dt = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200));
      return tk;
   endfunction

   // Response checker with random back-pressure.
   initial begin
      blend_result_type got, exp_r;
      forever begin
         idle_gap();
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         rsp_tready <= 1'b0;
         got = '{rsp_tdata[18:0], rsp_tuser, rsp_tdata[33:19], rsp_tdata[52:34],
                 rsp_tdata[53], rsp_tdata[54]};
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            exp_r = expected_q.pop_front();
            if (got.fused !== exp_r.fused) begin
               $error("fused_angle: expected %0d, got %0d", exp_r.fused, got.fused);
               failures++;
            end
            if (got.src !== exp_r.src) begin
               $error("source: expected %0d, got %0d", exp_r.src, got.src);
               failures++;
            end
            if (got.wgt !== exp_r.wgt) begin
               $error("blend_weight: expected %0d, got %0d", exp_r.wgt, got.wgt);
               failures++;
            end
            if (got.gap !== exp_r.gap) begin
               $error("angle_gap: expected %0d, got %0d",
                      $signed(exp_r.gap), $signed(got.gap));
               failures++;
            end
            if (got.fault !== exp_r.fault) begin
               $error("mismatch_fault: expected %0d, got %0d", exp_r.fault, got.fault);
               failures++;
            end
            if (got.trans !== exp_r.trans) begin
               $error("in_transition: expected %0d, got %0d", exp_r.trans, got.trans);
               failures++;
            end
         end
         @(posedge clock);
      end
   end

   // Stimulus: directed table, then random phases under several settings.
   initial begin
      row_type rows[$];
      row_type rw;
      blend_result_type none;
      int phase;
      none = '0;
      for (int i = 0; i < 8; i++) thr[i] = 0;
      p_weight = 0; p_hall_side = 1; p_obs_side = 0; p_count = 0; p_fault = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset every threshold is zero: speed zero is the Hall region and any
      // other speed the observer region, the weight climbs by one per tick and any
      // nonzero gap counts as a mismatch.
      rw.tk = '{19'd1000, 19'd1000, 1, 1, 16'd0, 16'd0};
      rw.fixed = 1; rw.res = '{19'd1000, SRC_HALL, 15'd0, 19'd0, 1'b0, 1'b0};
      rows.push_back(rw);
      rw.tk = '{19'd0, 19'd411774, 0, 1, 16'h8000, 16'hFFFF};
      rw.fixed = 1; rw.res = '{19'd411774, SRC_OBS, 15'd1, 19'h7FFFF, 1'b1, 1'b0};
      rows.push_back(rw);
      rw.tk = '{19'd411774, 19'd0, 1, 0, 16'h7FFF, 16'd0};
      rw.fixed = 1; rw.res = '{19'd411774, SRC_HALL, 15'd2, 19'd1, 1'b1, 1'b0};
      rows.push_back(rw);
      rw.fixed = 0; rw.res = none;
      rw.tk = '{19'h7FFFF, 19'h7FFFF, 1, 1, 16'hFFFF, 16'd100};
      rows.push_back(rw);
      rw.tk = '{19'd0, 19'd205888, 1, 1, 16'd1, 16'd1};
      rows.push_back(rw);
      rw.tk = '{19'd205888, 19'd0, 1, 1, 16'h8001, 16'd65535};
      rows.push_back(rw);
      foreach (rows[i]) send_tick(rows[i].tk, rows[i].fixed, rows[i].res);
      drain();

      // Directed ramp walk through every region with a realistic setup.
      set_thresholds(100, 400, 1200, 2000);
      write_reg(REG_MIS_LIMIT, 3000);
      write_reg(REG_MIS_COUNT, 3);
      write_reg(REG_RATE_UP, 32767);
      write_reg(REG_RATE_DOWN, 32767);
      for (int sp = 0; sp <= 2200; sp += 140) begin
         rw.tk = '{19'd411000, 19'd800, 1, 1, 16'(sp), 16'd65535};
         send_tick(rw.tk, 0, none);
      end
      // Wait until every response of the ramp walk is back.
      while (expected_q.size() != 0) @(posedge clock);

      for (phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: begin
               set_thresholds($urandom_range(0, 300), $urandom_range(300, 900),
                              $urandom_range(900, 1800), $urandom_range(1800, 3000));
               write_reg(REG_MIS_LIMIT, $urandom_range(500, 8000));
               write_reg(REG_MIS_COUNT, $urandom_range(0, 10));
               write_reg(REG_RATE_UP, $urandom_range(1000, 32767));
               write_reg(REG_RATE_DOWN, $urandom_range(1000, 32767));
            end
            1: begin
               set_thresholds(32767, 32767, 32767, 32767);
               write_reg(REG_MIS_LIMIT, 205888);
               write_reg(REG_MIS_COUNT, 65535);
               write_reg(REG_RATE_UP, 32767);
               write_reg(REG_RATE_DOWN, 0);
            end
            2: begin
               set_thresholds(0, 0, 0, 32767);
               write_reg(REG_MIS_LIMIT, 0);
               write_reg(REG_MIS_COUNT, 0);
               write_reg(REG_RATE_UP, 0);
               write_reg(REG_RATE_DOWN, 32767);
            end
            3: begin
               // Inconsistent and coinciding thresholds.
               set_thresholds(1500, 500, 500, 800);
               write_reg(REG_MIS_LIMIT, 262143);
               write_reg(REG_MIS_COUNT, 2);
            end
            default: begin
               set_thresholds($urandom_range(0, 200), $urandom_range(200, 1000),
                              $urandom_range(1000, 2000), $urandom_range(2000, 3000));
               write_reg(REG_MIS_LIMIT, $urandom_range(0, 6000));
               write_reg(REG_MIS_COUNT, $urandom_range(0, 5));
               write_reg(REG_RATE_UP, $urandom);
               write_reg(REG_RATE_DOWN, $urandom);
            end
         endcase
         repeat (100) begin
            idle_gap();
            send_tick(random_tick(), 0, none);
         end
      end
      drain();
      if (failures == 0 && expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
